/* hdl/tpi_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpi_pkg
// Shared types, codes and sizes for the time-stamped pose interpolator.
// ----------------------------------------------------------------------------
package tpi_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int FRAC_BITS   = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int POSE_W      = 6 * 32;
  localparam int ALPHA_W     = FRAC_BITS + 1;
  localparam int DIVC_W      = $clog2(FRAC_BITS + 1);

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_QUERY = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BEFORE = 2'd1;
  localparam logic [1:0] ST_AFTER  = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef enum logic [1:0] {OP_LOAD, OP_QUERY, OP_CLEAR, OP_NOP} op_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [31:0]        time_req;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_z;
    logic signed [31:0] roll;
    logic signed [31:0] pitch;
    logic signed [31:0] yaw;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] out_y;
    logic signed [31:0] out_x;
    logic signed [31:0] out_z;
    logic signed [31:0] out_roll;
    logic signed [31:0] out_pitch;
    logic signed [31:0] out_yaw;
    logic [CNT_W-1:0]   entry_count;
  } out_t;

  // pose packed with y in the lowest word, yaw in the highest
  typedef struct packed {
    op_t               op;
    logic [31:0]       time_req;
    logic [POSE_W-1:0] pose;
  } qent_t;

  typedef struct packed {
    logic  valid;
    qent_t ent;
  } head_t;

endpackage

/* hdl/timestamped_pose_interpolator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamped_pose_interpolator
// Table of time-stamped poses with lower-bound search and linear
// interpolation between neighbouring entries.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a rising edge with start high and busy low; it
//   carries req_type, a time and, for loads, a six-value pose. A two-entry
//   queue stands between intake and execution, so busy rises only when two
//   requests are waiting behind the one in progress.
//   Each request gives exactly one result, shown for one cycle with
//   out_valid high; the receiver cannot stall, so none is held.
//   Loads, clears and unused codes pass from the queue head through the
//   capture and dispatch states to the result. A query runs the search
//   probes (ceil(log2(n+1)) probes for n entries), each a read of the
//   single-port time memory and a compare, then closes the search and
//   reads both entries, runs the bit-serial fraction division and the
//   shared multiplier for six values. The table holds up to 1024 entries.
//   Reset empties the queue and the entry count; the memories are not
//   cleared, and only entries written since the last clear are read.
// ----------------------------------------------------------------------------
module timestamped_pose_interpolator import tpi_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_item,
  output logic out_valid,
  output out_t out_item
);

  head_t head;
  logic  pop;

  tpi_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .head(head), .pop(pop)
  );

  tpi_back u_back (
    .clk(clk), .rst_n(rst_n), .head(head), .pop(pop),
    .out_valid(out_valid), .out_item(out_item)
  );

endmodule

/* hdl/tpi_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpi_ram
// Single-port RAM, one write or read address per cycle, registered read.
// ----------------------------------------------------------------------------
module tpi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

endmodule

/* hdl/tpi_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpi_front
// Request intake: decodes the request type and holds up to two requests.
// ----------------------------------------------------------------------------
module tpi_front import tpi_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  output logic  busy,
  input  in_t   in_item,
  output head_t head,
  input  logic  pop
);

  qent_t      q_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;
  qent_t      ent;
  logic       push;

  always_comb begin
    ent.time_req = in_item.time_req;
    ent.pose     = {in_item.yaw, in_item.pitch, in_item.roll,
                    in_item.pos_z, in_item.pos_x, in_item.pos_y};
    unique case (in_item.req_type)
      REQ_LOAD:  ent.op = OP_LOAD;
      REQ_QUERY: ent.op = OP_QUERY;
      REQ_CLEAR: ent.op = OP_CLEAR;
      REQ_NONE:  ent.op = OP_NOP;
      default:   ent.op = OP_NOP;
    endcase
  end

  assign busy       = (cnt_r == 2'd2);
  assign push       = start && !busy;
  assign head.valid = (cnt_r != 2'd0);
  assign head.ent   = q_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        q_r[wr_r] <= ent;
        wr_r      <= ~wr_r;
      end
      if (pop) rd_r <= ~rd_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

/* hdl/tpi_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpi_back
// Request execution: table writes and clears, lower-bound search, serial division
// for the fraction and one shared multiplier for the six interpolations.
// ----------------------------------------------------------------------------
module tpi_back import tpi_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  head_t head,
  output logic  pop,
  output logic  out_valid,
  output out_t  out_item
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_SRCH, S_CMP, S_HI, S_HIW, S_LOW, S_DIV0, S_DIV, S_MUL, S_ADD
  } state_t;

  state_t                    state_r;
  qent_t                     cur_r;
  logic [CNT_W-1:0]          count_r, base_r, len_r;
  logic [IDX_W-1:0]          mid_r;
  logic signed [31:0]        org_r [3];
  logic [31:0]               t_hi_r, dt_r, span_r, rem_r;
  logic [POSE_W-1:0]         p_hi_r, p_lo_r, res_r;
  logic [FRAC_BITS-1:0]      quo_r;
  logic [DIVC_W-1:0]         divc_r;
  logic [ALPHA_W-1:0]        alpha_r;
  logic [2:0]                elem_r;
  logic signed [33+ALPHA_W:0] prod_r;
  logic                      out_valid_r;
  out_t                      out_r;

  logic                      ram_we;
  logic [IDX_W-1:0]          ram_addr;
  logic [31:0]               ram_t;
  logic [POSE_W-1:0]         ram_p, wr_pose;
  logic [CNT_W-1:0]          half;
  logic [CNT_W-1:0]          mid_sum;
  logic [32:0]               rem_sh;
  logic                      rem_ge;
  logic [31:0]               rem_next;
  logic [FRAC_BITS-1:0]      quo_next;
  logic signed [31:0]        p1, p2;
  logic signed [32:0]        diff;
  logic signed [33+ALPHA_W:0] prod_sh;
  logic signed [32:0]        interp;

  function automatic logic [31:0] sat32(input logic signed [32:0] v);
    if (v[32] != v[31]) return v[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    return v[31:0];
  endfunction

  function automatic out_t mk_out(input logic [1:0] st, input logic [POSE_W-1:0] p,
                                  input logic [CNT_W-1:0] c);
    out_t o;
    o.status      = st;
    o.out_y       = p[31:0];
    o.out_x       = p[63:32];
    o.out_z       = p[95:64];
    o.out_roll    = p[127:96];
    o.out_pitch   = p[159:128];
    o.out_yaw     = p[191:160];
    o.entry_count = c;
    return o;
  endfunction

  // positions relative to the origin; the first load sets the origin itself
  always_comb begin
    logic signed [31:0] org;
    wr_pose = cur_r.pose;
    for (int i = 0; i < 3; i++) begin
      org = (count_r == '0) ? $signed(cur_r.pose[i*32 +: 32]) : org_r[i];
      wr_pose[i*32 +: 32] = sat32(33'($signed(cur_r.pose[i*32 +: 32])) - 33'(org));
    end
  end

  assign half    = len_r >> 1;
  assign mid_sum = base_r + half;

  always_comb begin
    ram_we   = 1'b0;
    ram_addr = '0;
    unique case (state_r)
      S_DISP: begin
        ram_we   = (cur_r.op == OP_LOAD) && (count_r != CNT_W'(TABLE_DEPTH));
        ram_addr = count_r[IDX_W-1:0];
      end
      S_SRCH:  ram_addr = mid_sum[IDX_W-1:0];
      S_HI:    ram_addr = base_r[IDX_W-1:0];
      S_HIW:   ram_addr = base_r[IDX_W-1:0] - 1'b1;
      default: ram_addr = '0;
    endcase
  end

  tpi_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_time_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(cur_r.time_req), .rdata(ram_t)
  );

  tpi_ram #(.WIDTH(POSE_W), .DEPTH(TABLE_DEPTH)) u_pose_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(wr_pose), .rdata(ram_p)
  );

  // one restoring division step; remainder stays below the span
  assign rem_sh   = {rem_r, 1'b0};
  assign rem_ge   = rem_sh >= {1'b0, span_r};
  assign rem_next = rem_ge ? 32'(rem_sh - {1'b0, span_r}) : rem_sh[31:0];
  assign quo_next = {quo_r[FRAC_BITS-2:0], rem_ge};

  assign p1      = $signed(p_lo_r[elem_r*32 +: 32]);
  assign p2      = $signed(p_hi_r[elem_r*32 +: 32]);
  assign diff    = 33'(p2) - 33'(p1);
  assign prod_sh = prod_r >>> FRAC_BITS;
  assign interp  = 33'(p1) + prod_sh[32:0];

  assign pop = (state_r == S_IDLE) && head.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (head.valid) begin
            cur_r   <= head.ent;
            state_r <= S_DISP;
          end
        end
        S_DISP: begin
          unique case (cur_r.op)
            OP_LOAD: begin
              state_r     <= S_IDLE;
              out_valid_r <= 1'b1;
              if (count_r == CNT_W'(TABLE_DEPTH)) begin
                out_r <= mk_out(ST_FULL, '0, count_r);
              end else begin
                if (count_r == '0) begin
                  for (int i = 0; i < 3; i++) org_r[i] <= cur_r.pose[i*32 +: 32];
                end
                count_r <= count_r + 1'b1;
                out_r   <= mk_out(ST_OK, '0, count_r + 1'b1);
              end
            end
            OP_QUERY: begin
              if (count_r == '0) begin
                state_r     <= S_IDLE;
                out_valid_r <= 1'b1;
                out_r       <= mk_out(ST_AFTER, '0, count_r);
              end else begin
                base_r  <= '0;
                len_r   <= count_r;
                state_r <= S_SRCH;
              end
            end
            OP_CLEAR: begin
              count_r     <= '0;
              state_r     <= S_IDLE;
              out_valid_r <= 1'b1;
              out_r       <= mk_out(ST_OK, '0, '0);
            end
            default: begin
              state_r     <= S_IDLE;
              out_valid_r <= 1'b1;
              out_r       <= mk_out(ST_OK, '0, count_r);
            end
          endcase
        end
        S_SRCH: begin
          if (len_r == '0) begin
            state_r <= S_HI;
          end else begin
            mid_r   <= mid_sum[IDX_W-1:0];
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          if (ram_t < cur_r.time_req) begin
            base_r <= CNT_W'(mid_r) + 1'b1;
            len_r  <= len_r - half - 1'b1;
          end else begin
            len_r  <= half;
          end
          state_r <= S_SRCH;
        end
        S_HI: begin
          if (base_r >= count_r) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
            out_r       <= mk_out(ST_AFTER, '0, count_r);
          end else begin
            state_r <= S_HIW;
          end
        end
        S_HIW: begin
          t_hi_r <= ram_t;
          p_hi_r <= ram_p;
          if (ram_t == cur_r.time_req) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
            out_r       <= mk_out(ST_OK, ram_p, count_r);
          end else if (base_r == '0) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
            out_r       <= mk_out(ST_BEFORE, '0, count_r);
          end else begin
            state_r <= S_LOW;
          end
        end
        S_LOW: begin
          dt_r    <= cur_r.time_req - ram_t;
          span_r  <= t_hi_r - ram_t;
          p_lo_r  <= ram_p;
          state_r <= S_DIV0;
        end
        S_DIV0: begin
          elem_r <= '0;
          if (span_r == '0) begin
            alpha_r <= '0;
            state_r <= S_MUL;
          end else if (dt_r >= span_r) begin
            alpha_r <= ALPHA_W'(1) << FRAC_BITS;
            state_r <= S_MUL;
          end else begin
            rem_r   <= dt_r;
            quo_r   <= '0;
            divc_r  <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r  <= rem_next;
          quo_r  <= quo_next;
          divc_r <= divc_r + 1'b1;
          if (divc_r == DIVC_W'(FRAC_BITS - 1)) begin
            alpha_r <= {1'b0, quo_next};
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= diff * $signed({1'b0, alpha_r});
          state_r <= S_ADD;
        end
        S_ADD: begin
          res_r[elem_r*32 +: 32] <= interp[31:0];
          if (elem_r == 3'd5) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
            out_r       <= mk_out(ST_OK, {interp[31:0], res_r[159:0]}, count_r);
          end else begin
            elem_r  <= elem_r + 1'b1;
            state_r <= S_MUL;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.status == ST_FULL) |-> out_r.entry_count == CNT_W'(TABLE_DEPTH))
    else $error("full status with table not full");
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");
  a_probe_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CMP |-> $past(state_r) == S_SRCH)
    else $error("search compare without a probe read");
`endif

endmodule
